// ----- rtl/itp_pkg.sv -----
package itp_pkg;

  // Default operator stack depth.
  localparam int STACK_DEPTH_DEF = 32;

  // ASCII codes of the characters the converter reacts to.
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Error codes carried with each result item.
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CLOSE = 2'd1,
    ERR_OPEN  = 2'd2,
    ERR_FULL  = 2'd3
  } itp_err_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OPER,
    ST_CLOSE,
    ST_FLUSH
  } itp_state_t;

  // Command from the controller to the stack chain.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } itp_stk_ctl_t;

  // Status of the stack chain seen by the controller.
  typedef struct packed {
    logic       empty;
    logic       full;
    logic       one_left;
    logic       has_open;
    logic [7:0] top;
  } itp_stk_st_t;

  // Operator weight, offset by one so that it compares unsigned:
  // '$' and anything else map to 0, '+' and '-' to 2, '*' and '/' to 3.
  function automatic logic [1:0] weight_of(input logic [7:0] c);
    logic [1:0] w;
    w = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) begin
      w = 2'd2;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      w = 2'd3;
    end
    return w;
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_DOLLAR);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

endpackage

// ----- rtl/itp_cell.sv -----
module itp_cell (
  input  logic       clk,
  input  logic       push,
  input  logic       pop,
  input  logic [7:0] up_data,
  input  logic [7:0] down_data,
  output logic [7:0] data
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  // A push takes the entry from the cell above, a pop the one from below.
  always_comb begin
    data_nxt = data_r;
    if (push) begin
      data_nxt = up_data;
    end else if (pop) begin
      data_nxt = down_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ----- rtl/itp_stack.sv -----
module itp_stack #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itp_pkg::itp_stk_ctl_t ctl,
  output itp_pkg::itp_stk_st_t  st
);
  import itp_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [7:0]       cell_data [STACK_DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] open_r;
  logic [CNT_W-1:0] open_nxt;

  // Cell 0 is the top of the stack; entries shift down on push, up on pop.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] up_d;
    logic [7:0] down_d;
    if (i == 0) begin : g_first
      assign up_d = ctl.data;
    end else begin : g_mid
      assign up_d = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_d = cell_data[i];
    end else begin : g_inner
      assign down_d = cell_data[i+1];
    end
    itp_cell u_cell (
      .clk       (clk),
      .push      (ctl.push),
      .pop       (ctl.pop),
      .up_data   (up_d),
      .down_data (down_d),
      .data      (cell_data[i])
    );
  end

  // Fill count and count of stacked open parentheses.
  always_comb begin
    count_nxt = count_r;
    open_nxt  = open_r;
    if (ctl.push) begin
      count_nxt = count_r + CNT_W'(1);
      if (ctl.data == CH_LPAREN) begin
        open_nxt = open_r + CNT_W'(1);
      end
    end else if (ctl.pop) begin
      count_nxt = count_r - CNT_W'(1);
      if (cell_data[0] == CH_LPAREN) begin
        open_nxt = open_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      open_r  <= '0;
    end else begin
      count_r <= count_nxt;
      open_r  <= open_nxt;
    end
  end

  assign st.empty    = (count_r == '0);
  assign st.full     = (count_r == CNT_W'(STACK_DEPTH));
  assign st.one_left = (count_r == CNT_W'(1));
  assign st.has_open = (open_r != '0);
  assign st.top      = cell_data[0];

endmodule

// ----- rtl/infix_to_postfix_converter.sv -----
// A result item is registered in the out_ registers and sits there until the receiver takes it.
// Processing: a letter, a '(' or any other character is handled on decode; an operator first pops
// the entries that outweigh or tie it, then is pushed if there is room; a ')' or an end item pops
// entry by entry, a ')' down to its '(' and an end item until the stack is empty. A held result item stalls it.
// Reset (rst_n low, synchronous) empties the stack and the output register; stack cell
// contents are not cleared and are never read before written.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_end_of_expr,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic       out_last,
  output logic [1:0] out_error_code
);
  import itp_pkg::*;

  itp_state_t   state_r;
  itp_state_t   state_nxt;
  logic [7:0]   op_r;
  logic [7:0]   op_nxt;
  itp_stk_ctl_t ctl;
  itp_stk_st_t  st;

  logic         out_valid_r;
  logic         out_valid_nxt;
  logic [7:0]   out_char_r;
  logic         out_char_valid_r;
  logic         out_last_r;
  itp_err_t     out_err_r;

  logic         out_free;
  logic         ld;
  logic [7:0]   res_char;
  logic         res_valid;
  logic         res_last;
  itp_err_t     res_err;

  itp_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .st    (st)
  );

  assign out_free = !out_valid_r || !out_stall;

  // Controller: decodes an item, then pops one stack entry per cycle while the output register is free.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    in_stall  = 1'b1;
    ctl       = '0;
    ld        = 1'b0;
    res_char  = 8'h00;
    res_valid = 1'b0;
    res_last  = 1'b0;
    res_err   = ERR_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          if (in_end_of_expr) begin
            if (st.empty) begin
              ld       = 1'b1;
              res_last = 1'b1;
            end else begin
              state_nxt = ST_FLUSH;
            end
          end else if (is_operator(in_char)) begin
            op_nxt    = in_char;
            state_nxt = ST_OPER;
          end else if (is_letter(in_char)) begin
            ld        = 1'b1;
            res_char  = in_char;
            res_valid = 1'b1;
          end else if (in_char == CH_LPAREN) begin
            if (st.full) begin
              ld      = 1'b1;
              res_err = ERR_FULL;
            end else begin
              ctl.push = 1'b1;
              ctl.data = in_char;
            end
          end else if (in_char == CH_RPAREN) begin
            if (!st.has_open) begin
              ld      = 1'b1;
              res_err = ERR_CLOSE;
            end else begin
              state_nxt = ST_CLOSE;
            end
          end
        end
      end
      ST_OPER: begin
        if (out_free) begin
          if (!st.empty && st.top != CH_LPAREN &&
              weight_of(st.top) >= weight_of(op_r)) begin
            ctl.pop   = 1'b1;
            ld        = 1'b1;
            res_char  = st.top;
            res_valid = 1'b1;
          end else if (st.full) begin
            ld        = 1'b1;
            res_err   = ERR_FULL;
            state_nxt = ST_IDLE;
          end else begin
            ctl.push  = 1'b1;
            ctl.data  = op_r;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          ctl.pop = 1'b1;
          if (st.top == CH_LPAREN) begin
            state_nxt = ST_IDLE;
          end else begin
            ld        = 1'b1;
            res_char  = st.top;
            res_valid = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          ctl.pop   = 1'b1;
          ld        = 1'b1;
          res_char  = st.top;
          res_valid = 1'b1;
          res_last  = st.one_left;
          res_err   = (st.top == CH_LPAREN) ? ERR_OPEN : ERR_NONE;
          if (st.one_left) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  // Output register: holds a result item until the receiver takes it.
  assign out_valid_nxt = ld ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_char_r       <= res_char;
      out_char_valid_r <= res_valid;
      out_last_r       <= res_last;
      out_err_r        <= res_err;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_char_valid = out_char_valid_r;
  assign out_last       = out_last_r;
  assign out_error_code = out_err_r;

endmodule
